[design/mie_pkg.sv]
package mie_pkg;

   // Width of the value, modulus, inverse and gcd fields on the ports
   localparam int FIELD_W = 63;
   // Default operand width of the datapath
   localparam int DATA_WIDTH_DEF = 63;

   typedef struct packed {
      logic [FIELD_W-1:0] value;
      logic [FIELD_W-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] inverse_value;
      logic [FIELD_W-1:0] common_divisor;
      logic               invertible;
   } rsp_type;

   // Datapath operations, one per control word
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_DIV_EUCLID,
      OP_DIV_REDUCE,
      OP_DIV_STEP,
      OP_UPDATE,
      OP_FIX_SIGN,
      OP_SAVE_REM,
      OP_EMIT
   } op_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_RC_ZERO,
      COND_DIV_MORE,
      COND_LT_N,
      COND_OUT_FULL
   } cond_type;

   localparam int STEP_W = 4;

   // Program addresses
   localparam logic [STEP_W-1:0] STEP_IDLE       = 4'd0;
   localparam logic [STEP_W-1:0] STEP_TEST       = 4'd1;
   localparam logic [STEP_W-1:0] STEP_DIV_START  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DIV_LOOP   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_UPDATE     = 4'd4;
   localparam logic [STEP_W-1:0] STEP_FIX        = 4'd5;
   localparam logic [STEP_W-1:0] STEP_RANGE      = 4'd6;
   localparam logic [STEP_W-1:0] STEP_RED_START  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_RED_LOOP   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_RED_SAVE   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_EMIT       = 4'd10;
   localparam logic [STEP_W-1:0] STEP_RETURN     = 4'd11;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   // Status flags from the datapath to the sequencer
   typedef struct packed {
      logic no_req;
      logic rc_zero;
      logic div_more;
      logic t_lt_n;
      logic out_full;
   } status_type;

   // Microprogram: execute op, then jump to target when cond holds, else advance
   function automatic ctrl_type micro_rom(input logic [STEP_W-1:0] idx);
      ctrl_type w;
      unique case (idx)
         STEP_IDLE:      w = '{OP_LOAD,       COND_NO_REQ,   STEP_IDLE};
         STEP_TEST:      w = '{OP_NOP,        COND_RC_ZERO,  STEP_FIX};
         STEP_DIV_START: w = '{OP_DIV_EUCLID, COND_NEVER,    STEP_IDLE};
         STEP_DIV_LOOP:  w = '{OP_DIV_STEP,   COND_DIV_MORE, STEP_DIV_LOOP};
         STEP_UPDATE:    w = '{OP_UPDATE,     COND_ALWAYS,   STEP_TEST};
         STEP_FIX:       w = '{OP_FIX_SIGN,   COND_NEVER,    STEP_IDLE};
         STEP_RANGE:     w = '{OP_NOP,        COND_LT_N,     STEP_EMIT};
         STEP_RED_START: w = '{OP_DIV_REDUCE, COND_NEVER,    STEP_IDLE};
         STEP_RED_LOOP:  w = '{OP_DIV_STEP,   COND_DIV_MORE, STEP_RED_LOOP};
         STEP_RED_SAVE:  w = '{OP_SAVE_REM,   COND_NEVER,    STEP_IDLE};
         STEP_EMIT:      w = '{OP_EMIT,       COND_OUT_FULL, STEP_EMIT};
         STEP_RETURN:    w = '{OP_NOP,        COND_ALWAYS,   STEP_IDLE};
         default:        w = '{OP_NOP,        COND_ALWAYS,   STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

[design/modular_inverse_ext_euclid_top.sv]
// Modular inverse and gcd by the extended Euclidean algorithm.
// Request channel: req_valid / req_stall with req_data holding value and
// modulus. A request is taken only while the sequencer sits at its idle
// step; req_stall is high for the whole time an item is being worked on.
// Result channel: rsp_valid / rsp_stall with rsp_data holding the inverse,
// the gcd and the invertible flag; exactly one result per request.
// Each Euclid iteration runs the bit-serial restoring divider (one
// quotient bit per cycle), which also forms the quotient-times-coefficient
// product; a final reduction by the same divider follows when the
// coefficient needs it. The number of iterations k reaches about 90 for
// 63-bit operands. One item is in flight at a time.
// The finished result sits in an output register, so the next request is
// taken while the receiver stalls; a further result then waits at the emit
// step until the register is free. Reset returns the sequencer to idle,
// empties the output register and holds req_stall high.
module modular_inverse_ext_euclid_top #(
   parameter int DATA_WIDTH = mie_pkg::DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mie_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mie_pkg::rsp_type rsp_data
);
   import mie_pkg::*;

   op_type     op;
   status_type status;

   // Accept a request only at the idle step and outside reset
   assign req_stall = reset | (op != OP_LOAD);

   mie_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   mie_dp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (status)
   );

endmodule

[design/mie_seq.sv]
module mie_seq (
   input  logic                clock,
   input  logic                reset,
   input  mie_pkg::status_type status,
   output mie_pkg::op_type     op
);
   import mie_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ctrl_type          word;
   logic              take_jump;

   // Fetch the control word of the current step
   assign word = micro_rom(step_ff);
   assign op   = word.op;

   // Evaluate the jump condition
   always_comb begin
      unique case (word.cond)
         COND_NEVER:    take_jump = 1'b0;
         COND_ALWAYS:   take_jump = 1'b1;
         COND_NO_REQ:   take_jump = status.no_req;
         COND_RC_ZERO:  take_jump = status.rc_zero;
         COND_DIV_MORE: take_jump = status.div_more;
         COND_LT_N:     take_jump = status.t_lt_n;
         COND_OUT_FULL: take_jump = status.out_full;
         default:       take_jump = 1'b1;
      endcase
      step_in = take_jump ? word.target : step_ff + 1'b1;
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

[design/mie_dp.sv]
module mie_dp #(
   parameter int DATA_WIDTH = mie_pkg::DATA_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  mie_pkg::op_type     op,
   input  logic                req_valid,
   input  mie_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mie_pkg::rsp_type    rsp_data,
   output mie_pkg::status_type status
);
   import mie_pkg::*;

   localparam int W     = DATA_WIDTH;
   localparam int CNT_W = $clog2(DATA_WIDTH);

   // Euclid remainders, Bezout coefficients (W+1 bit two's complement) and modulus
   logic [W-1:0]     rp_ff, rp_in, rc_ff, rc_in, n_ff, n_in;
   logic [W:0]       cp_ff, cp_in, cc_ff, cc_in;
   logic             nzero_ff, nzero_in;
   // Restoring divider with a shift-add product of quotient and coefficient
   logic [W-1:0]     den_ff, den_in, rem_ff, rem_in, quo_ff, quo_in;
   logic [W:0]       prod_ff, prod_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [W:0]       shifted, diff;
   logic             qbit;
   logic             out_full;
   logic             unit_gcd;

   // One divider step: bring down the next dividend bit, try to subtract
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign qbit    = ~diff[W];

   assign out_full = rsp_valid_ff & rsp_stall;
   assign unit_gcd = (rp_ff == W'(1)) & ~nzero_ff;

   always_comb begin
      rp_in        = rp_ff;
      rc_in        = rc_ff;
      n_in         = n_ff;
      cp_in        = cp_ff;
      cc_in        = cc_ff;
      nzero_in     = nzero_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      // Drop the result once taken
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      unique case (op)
         OP_NOP: begin
         end
         OP_LOAD: begin
            if (req_valid) begin
               rp_in    = req_data.modulus[W-1:0];
               rc_in    = req_data.value[W-1:0];
               n_in     = req_data.modulus[W-1:0];
               nzero_in = (req_data.modulus[W-1:0] == '0);
               cp_in    = '0;
               cc_in    = (W+1)'(1);
            end
         end
         OP_DIV_EUCLID: begin
            den_in  = rc_ff;
            quo_in  = rp_ff;
            rem_in  = '0;
            prod_in = '0;
            cnt_in  = CNT_W'(W - 1);
         end
         OP_DIV_REDUCE: begin
            den_in  = n_ff;
            quo_in  = cp_ff[W-1:0];
            rem_in  = '0;
            prod_in = '0;
            cnt_in  = CNT_W'(W - 1);
         end
         OP_DIV_STEP: begin
            rem_in  = qbit ? diff[W-1:0] : shifted[W-1:0];
            quo_in  = {quo_ff[W-2:0], qbit};
            prod_in = {prod_ff[W-1:0], 1'b0} + (qbit ? cc_ff : '0);
            cnt_in  = cnt_ff - 1'b1;
         end
         OP_UPDATE: begin
            rp_in = rc_ff;
            rc_in = rem_ff;
            cp_in = cc_ff;
            cc_in = cp_ff - prod_ff;
         end
         OP_FIX_SIGN: begin
            // Correct a negative coefficient by adding the modulus
            if (cp_ff[W]) begin
               cp_in = cp_ff + {1'b0, n_ff};
            end
         end
         OP_SAVE_REM: begin
            cp_in = {1'b0, rem_ff};
         end
         OP_EMIT: begin
            if (!out_full) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.common_divisor = FIELD_W'(rp_ff);
               rsp_data_in.invertible     = unit_gcd;
               rsp_data_in.inverse_value  = unit_gcd ? FIELD_W'(cp_ff[W-1:0]) : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Clear the result valid flag under reset, the rest free-running
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rp_ff       <= rp_in;
      rc_ff       <= rc_in;
      n_ff        <= n_in;
      cp_ff       <= cp_in;
      cc_ff       <= cc_in;
      nzero_ff    <= nzero_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      prod_ff     <= prod_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Report flags to the sequencer
   assign status.no_req   = ~req_valid;
   assign status.rc_zero  = (rc_ff == '0);
   assign status.div_more = (cnt_ff != '0);
   assign status.t_lt_n   = (cp_ff < {1'b0, n_ff});
   assign status.out_full = out_full;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/mie_checker.sv]
module mie_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mie_pkg::rsp_type rsp_data
);
   import mie_pkg::*;

   // Output register comes up empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Only one request in flight
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // Invertible only with a unit gcd
   a_unit_gcd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.invertible |-> rsp_data.common_divisor == FIELD_W'(1))
      else $error("invertible with gcd other than one");

   // No inverse without invertibility
   a_zero_inverse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.invertible |-> rsp_data.inverse_value == '0)
      else $error("inverse given for non-invertible value");

endmodule

bind modular_inverse_ext_euclid_top mie_checker u_checker (.*);
